[hdl/csv_byte_stream_parser_assert.svh]
// Assertion macros for the CSV byte stream parser, clocked on clk, disabled in rst.
`ifndef CSV_BYTE_STREAM_PARSER_ASSERT_SVH
`define CSV_BYTE_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication.
`define CSVP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSVP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/csvp_pkg.sv]
// Package: types, character codes and limits for the CSV byte stream parser.
`default_nettype none
package csvp_pkg;

  localparam int unsigned FIELD_CAPACITY  = 1024;
  localparam int unsigned COLUMN_CAPACITY = 26;
  localparam int unsigned ROW_CAPACITY    = 16384;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [9:0]  CHARS_MAX = 10'd1023;
  localparam logic [5:0]  COL_MAX   = 6'd63;
  localparam logic [13:0] ROW_MAX   = 14'd16383;

  // Capacity-derived caps on the configured limits.
  localparam logic [9:0]  LEN_CAP = 10'(FIELD_CAPACITY - 1);
  localparam logic [4:0]  COL_CAP = 5'(COLUMN_CAPACITY);
  localparam logic [13:0] ROW_CAP =
    (ROW_CAPACITY < 16383) ? 14'(ROW_CAPACITY) : 14'd16383;

  typedef enum logic [1:0] {
    EV_CHAR      = 2'd0,
    EV_FIELD_END = 2'd1,
    EV_ROW_END   = 2'd2,
    EV_UNTERM    = 2'd3
  } csvp_event_t;

  typedef enum logic [1:0] {
    CFG_MAX_COLUMNS     = 2'd0,
    CFG_MAX_FIELD_CHARS = 2'd1,
    CFG_MAX_ROWS        = 2'd2
  } csvp_cfg_idx_t;

  localparam logic [4:0]  MAX_COLUMNS_RST     = 5'd26;
  localparam logic [9:0]  MAX_FIELD_CHARS_RST = 10'd1023;
  localparam logic [14:0] MAX_ROWS_RST        = 15'd10000;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
  } csvp_in_t;

  typedef struct packed {
    csvp_event_t event_res;
    logic [7:0]  char_out;
    logic [5:0]  column;
    logic [13:0] row;
    logic [9:0]  field_length;
    logic        kept;
    logic [5:0]  widest_row;
  } csvp_out_t;

  typedef struct packed {
    logic [4:0]  max_columns;
    logic [9:0]  max_field_chars;
    logic [14:0] max_rows;
  } csvp_cfg_t;

  typedef struct packed {
    logic        inside_quotes;
    logic        quote_pending;
    logic        after_carriage_return;
    logic [9:0]  chars_in_field;
    logic [5:0]  column_count;
    logic [13:0] row_count;
    logic [5:0]  widest_seen;
  } csvp_state_t;

endpackage
`default_nettype wire

[hdl/csvp_step.sv]
// Combinational step: parser state and one input byte to next state and result.
`default_nettype none
module csvp_step (
  input  csvp_pkg::csvp_cfg_t   cfg,
  input  csvp_pkg::csvp_state_t st,
  input  csvp_pkg::csvp_in_t    item,
  output csvp_pkg::csvp_state_t st_next,
  output logic                  fire,
  output csvp_pkg::csvp_out_t   result
);

  logic [9:0]  len_lim;
  logic [4:0]  col_lim;
  logic [13:0] row_lim;
  logic        col_ok;
  logic        row_ok;
  logic [9:0]  len_cur;
  logic [9:0]  chars_inc;
  logic [5:0]  col_inc;
  logic [13:0] row_inc;
  logic [5:0]  row_fields;
  logic [5:0]  widest_upd;
  logic [7:0]  b;
  logic        cont;
  logic        do_char;
  logic        do_field;
  logic        do_row;
  logic        do_unterm;
  logic [7:0]  char_val;

  always_comb begin
    len_lim = (cfg.max_field_chars < csvp_pkg::LEN_CAP) ? cfg.max_field_chars
                                                        : csvp_pkg::LEN_CAP;
    col_lim = (cfg.max_columns < csvp_pkg::COL_CAP) ? cfg.max_columns : csvp_pkg::COL_CAP;
    row_lim = (cfg.max_rows < {1'b0, csvp_pkg::ROW_CAP}) ? cfg.max_rows[13:0]
                                                         : csvp_pkg::ROW_CAP;
    col_ok  = st.column_count < {1'b0, col_lim};
    row_ok  = st.row_count < row_lim;
    len_cur = (st.chars_in_field < len_lim) ? st.chars_in_field : len_lim;
    chars_inc = (st.chars_in_field < csvp_pkg::CHARS_MAX) ? st.chars_in_field + 10'd1
                                                          : csvp_pkg::CHARS_MAX;
    col_inc = (st.column_count < csvp_pkg::COL_MAX) ? st.column_count + 6'd1
                                                    : csvp_pkg::COL_MAX;
    row_inc = (st.row_count < csvp_pkg::ROW_MAX) ? st.row_count + 14'd1
                                                 : csvp_pkg::ROW_MAX;
    row_fields = col_inc;
    widest_upd = (row_fields > st.widest_seen) ? row_fields : st.widest_seen;
  end

  // Decide the action for this byte.
  always_comb begin
    b         = item.data_byte;
    cont      = 1'b1;
    do_char   = 1'b0;
    do_field  = 1'b0;
    do_row    = 1'b0;
    do_unterm = 1'b0;
    char_val  = b;
    st_next   = st;
    if (item.kind) begin
      if (st.inside_quotes && !st.quote_pending) begin
        do_unterm = 1'b1;
      end else begin
        do_row = 1'b1;
      end
      st_next = '0;
    end else begin
      if (st.after_carriage_return) begin
        st_next.after_carriage_return = 1'b0;
        if (b == csvp_pkg::CH_LF) begin
          cont = 1'b0;
        end
      end
      if (cont && st.inside_quotes) begin
        if (st.quote_pending) begin
          st_next.quote_pending = 1'b0;
          if (b == csvp_pkg::CH_QUOTE) begin
            do_char = 1'b1;
            cont    = 1'b0;
          end else begin
            st_next.inside_quotes = 1'b0;
          end
        end else if (b == csvp_pkg::CH_QUOTE) begin
          st_next.quote_pending = 1'b1;
          cont                  = 1'b0;
        end else begin
          do_char = 1'b1;
          cont    = 1'b0;
        end
      end
      if (cont) begin
        if (b == csvp_pkg::CH_QUOTE && st.chars_in_field == 10'd0) begin
          st_next.inside_quotes = 1'b1;
        end else if (b == csvp_pkg::CH_COMMA) begin
          do_field = 1'b1;
        end else if (b == csvp_pkg::CH_CR || b == csvp_pkg::CH_LF) begin
          if (b == csvp_pkg::CH_CR) begin
            st_next.after_carriage_return = 1'b1;
          end
          do_row = 1'b1;
        end else begin
          do_char = 1'b1;
        end
      end
      // Counter updates; the end-of-data path already cleared everything.
      if (do_char) begin
        st_next.chars_in_field = chars_inc;
      end
      if (do_field) begin
        st_next.column_count   = col_inc;
        st_next.chars_in_field = 10'd0;
      end
      if (do_row) begin
        st_next.widest_seen    = widest_upd;
        st_next.row_count      = row_inc;
        st_next.column_count   = 6'd0;
        st_next.chars_in_field = 10'd0;
      end
    end
  end

  // Build the result item.
  always_comb begin
    fire                = do_char | do_field | do_row | do_unterm;
    result              = '0;
    result.row          = st.row_count;
    result.column       = st.column_count;
    result.field_length = len_cur;
    result.widest_row   = st.widest_seen;
    if (do_char) begin
      result.event_res    = csvp_pkg::EV_CHAR;
      result.char_out     = char_val;
      result.field_length = (chars_inc < len_lim) ? chars_inc : len_lim;
      result.kept         = col_ok && row_ok && (st.chars_in_field < len_lim);
    end else if (do_field) begin
      result.event_res = csvp_pkg::EV_FIELD_END;
      result.kept      = col_ok && row_ok;
    end else if (do_row) begin
      result.event_res  = csvp_pkg::EV_ROW_END;
      result.column     = row_fields;
      result.kept       = row_ok;
      result.widest_row = widest_upd;
    end else begin
      result.event_res = csvp_pkg::EV_UNTERM;
      result.kept      = 1'b0;
    end
  end

endmodule
`default_nettype wire

[hdl/csv_byte_stream_parser.sv]
// Top level of the CSV byte stream parser: handshakes, registers, result register.
`default_nettype none
// Streaming CSV parser in the RFC 4180 manner. Each transfer on the input
// channel carries one byte (kind 0) or an end-of-data mark (kind 1); each
// transfer causes zero or one result: a field character, a field end on a
// comma, a row end on CR, LF or CRLF, or an unterminated-quote report when
// data ends inside an open quoted field. Every result carries its column,
// row, stored field length, a kept flag against the configured column, row
// and length limits, and the widest row finished so far. End of data acts
// as a final LF, unless it ends an open quoted field, and then returns the
// parser to its reset state; the limit registers keep their values. Rate:
// one input byte per clock while no result is stalled. Each byte passes
// through the step logic in the cycle it is taken and its result lands in
// the output register on that edge, so output valid rises in the cycle
// after the input transfer. The input stalls only while the output register
// holds a result that the consumer is stalling. Write the limit registers
// through the config channel (always ready) only while the parser is idle.
module csv_byte_stream_parser (
  input  logic                clk,
  input  logic                rst,
  // Input byte channel
  input  logic                in_valid,
  output logic                in_stall,
  input  csvp_pkg::csvp_in_t  in_data,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output csvp_pkg::csvp_out_t out_data,
  // Config write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [14:0]         cfg_data
);

  csvp_pkg::csvp_cfg_t   cfg;
  csvp_pkg::csvp_state_t st;
  csvp_pkg::csvp_state_t st_next;
  csvp_pkg::csvp_out_t   result;
  logic                  fire;
  logic                  in_take;
  logic                  out_take;

  // Hold the input only while a finished result is stalled downstream.
  assign in_stall  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // Limit registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_columns     <= csvp_pkg::MAX_COLUMNS_RST;
      cfg.max_field_chars <= csvp_pkg::MAX_FIELD_CHARS_RST;
      cfg.max_rows        <= csvp_pkg::MAX_ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csvp_pkg::CFG_MAX_COLUMNS:     cfg.max_columns     <= cfg_data[4:0];
        csvp_pkg::CFG_MAX_FIELD_CHARS: cfg.max_field_chars <= cfg_data[9:0];
        csvp_pkg::CFG_MAX_ROWS:        cfg.max_rows        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  csvp_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_data),
    .st_next (st_next),
    .fire    (fire),
    .result  (result)
  );

  // Advance the parser state on every accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_take) begin
      st <= st_next;
    end
  end

  // Result register: load on a firing transfer, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && fire) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && fire) begin
      out_data <= result;
    end
  end

`include "csv_byte_stream_parser_assert.svh"

  `CSVP_ASSERT_NXT(a_fire_loads_out, in_take && fire, out_valid, "firing transfer left no result")
  `CSVP_ASSERT_IMP(a_pending_quoted, st.quote_pending, st.inside_quotes, "stray pending quote")
  `CSVP_ASSERT_IMP(a_cr_unquoted, st.after_carriage_return, !st.inside_quotes, "CR flag in quotes")
  `CSVP_ASSERT_NXT(a_silent_no_load, in_take && !fire && !out_valid, !out_valid, "result appeared without cause")

endmodule
`default_nettype wire

[test/tb_csv_byte_stream_parser.sv]
// Testbench for the CSV byte stream parser: directed and random byte streams, checked event by event.
`default_nettype none
module tb_csv_byte_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  csvp_pkg::csvp_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  csvp_pkg::csvp_out_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [14:0]         cfg_data = '0;

  csv_byte_stream_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  // Idle rates in percent for the byte sender and the event receiver.
  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 78;

  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned bytes_taken = 0;
  int unsigned events_seen = 0;
  int unsigned hang_count = 0;

  // Shadow parser: limit registers and scan state.
  int unsigned lim_cols  = csvp_pkg::MAX_COLUMNS_RST;
  int unsigned lim_chars = csvp_pkg::MAX_FIELD_CHARS_RST;
  int unsigned lim_rows  = csvp_pkg::MAX_ROWS_RST;
  bit          quoted, quote_wait, after_cr;
  int unsigned chars_seen, col_idx, row_idx, widest;

  csvp_pkg::csvp_out_t expected_events[$];

  function automatic int unsigned min2(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic int unsigned len_cap();
    return min2(min2(lim_chars, csvp_pkg::FIELD_CAPACITY - 1), csvp_pkg::CHARS_MAX);
  endfunction

  function automatic bit col_in();
    return col_idx < min2(lim_cols, csvp_pkg::COLUMN_CAPACITY);
  endfunction

  function automatic bit row_in();
    return row_idx < min2(min2(lim_rows, csvp_pkg::ROW_CAPACITY), csvp_pkg::ROW_MAX);
  endfunction

  function automatic csvp_pkg::csvp_out_t pack_event(input csvp_pkg::csvp_event_t ev,
                                                     input logic [7:0] ch,
                                                     input int unsigned col,
                                                     input int unsigned len,
                                                     input bit keep);
    csvp_pkg::csvp_out_t r;
    r.event_res    = ev;
    r.char_out     = ch;
    r.column       = col[5:0];
    r.row          = row_idx[13:0];
    r.field_length = len[9:0];
    r.kept         = keep;
    r.widest_row   = widest[5:0];
    return r;
  endfunction

  // Store one field character; the count saturates, the reported length stops at the limit.
  function automatic csvp_pkg::csvp_out_t field_char(input logic [7:0] ch);
    int unsigned lim;
    bit          keep;
    lim  = len_cap();
    keep = col_in() && row_in() && (chars_seen < lim);
    if (chars_seen < csvp_pkg::CHARS_MAX) chars_seen++;
    return pack_event(csvp_pkg::EV_CHAR, ch, col_idx, min2(chars_seen, lim), keep);
  endfunction

  // Close the row: report field count, then advance the row index.
  function automatic csvp_pkg::csvp_out_t close_row();
    int unsigned         n;
    int unsigned         len;
    bit                  keep;
    csvp_pkg::csvp_out_t r;
    n    = (col_idx < csvp_pkg::COL_MAX) ? col_idx + 1 : csvp_pkg::COL_MAX;
    len  = min2(chars_seen, len_cap());
    keep = row_in();
    if (n > widest) widest = n;
    r = pack_event(csvp_pkg::EV_ROW_END, 8'h00, n, len, keep);
    if (row_idx < csvp_pkg::ROW_MAX) row_idx++;
    col_idx    = 0;
    chars_seen = 0;
    return r;
  endfunction

  // Advance the shadow parser by one input transfer; return 1 if it yields an event.
  function automatic bit parse_item(input csvp_pkg::csvp_in_t it,
                                    output csvp_pkg::csvp_out_t res);
    logic [7:0] b;
    b   = it.data_byte;
    res = '0;
    if (it.kind) begin
      // End of data acts as a final LF; an open quote discards the field instead.
      if (quoted && !quote_wait)
        res = pack_event(csvp_pkg::EV_UNTERM, 8'h00, col_idx,
                         min2(chars_seen, len_cap()), 1'b0);
      else
        res = close_row();
      quoted     = 1'b0;
      quote_wait = 1'b0;
      after_cr   = 1'b0;
      chars_seen = 0;
      col_idx    = 0;
      row_idx    = 0;
      widest     = 0;
      return 1'b1;
    end
    if (after_cr) begin
      after_cr = 1'b0;
      if (b == csvp_pkg::CH_LF) return 1'b0;
    end
    if (quoted) begin
      if (quote_wait) begin
        quote_wait = 1'b0;
        if (b == csvp_pkg::CH_QUOTE) begin
          res = field_char(csvp_pkg::CH_QUOTE);
          return 1'b1;
        end
        quoted = 1'b0;
      end else if (b == csvp_pkg::CH_QUOTE) begin
        quote_wait = 1'b1;
        return 1'b0;
      end else begin
        res = field_char(b);
        return 1'b1;
      end
    end
    if (b == csvp_pkg::CH_QUOTE && chars_seen == 0) begin
      quoted = 1'b1;
      return 1'b0;
    end
    if (b == csvp_pkg::CH_COMMA) begin
      res = pack_event(csvp_pkg::EV_FIELD_END, 8'h00, col_idx, min2(chars_seen, len_cap()),
                       col_in() && row_in());
      if (col_idx < csvp_pkg::COL_MAX) col_idx++;
      chars_seen = 0;
      return 1'b1;
    end
    if (b == csvp_pkg::CH_CR || b == csvp_pkg::CH_LF) begin
      if (b == csvp_pkg::CH_CR) after_cr = 1'b1;
      res = close_row();
      return 1'b1;
    end
    res = field_char(b);
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Monitor: check results, predict on accepted bytes, track register writes, watch for hangs.
  always @(posedge clk) begin
    csvp_pkg::csvp_out_t want;
    csvp_pkg::csvp_out_t next_event;
    bit                  moved;
    if (!rst) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        events_seen++;
        if (expected_events.size() == 0) begin
          $error("unexpected event %0d at row %0d column %0d",
                 out_data.event_res, out_data.row, out_data.column);
          errors++;
        end else begin
          want = expected_events.pop_front();
          compare_field("event_res", want.event_res, out_data.event_res);
          compare_field("char_out", want.char_out, out_data.char_out);
          compare_field("column", want.column, out_data.column);
          compare_field("row", want.row, out_data.row);
          compare_field("field_length", want.field_length, out_data.field_length);
          compare_field("kept", want.kept, out_data.kept);
          compare_field("widest_row", want.widest_row, out_data.widest_row);
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        bytes_taken++;
        if (parse_item(in_data, next_event)) expected_events.push_back(next_event);
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          csvp_pkg::CFG_MAX_COLUMNS:     lim_cols  = cfg_data[4:0];
          csvp_pkg::CFG_MAX_FIELD_CHARS: lim_chars = cfg_data[9:0];
          csvp_pkg::CFG_MAX_ROWS:        lim_rows  = cfg_data[14:0];
          default: ;
        endcase
      end
      hang_count = moved ? 0 : hang_count + 1;
      if (hang_count >= HANG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver: stall at random at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one item, idling first at the current rate; hold it until the transfer.
  task automatic send_item(input logic k, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: k, data_byte: b};
    bytes_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b);
  endtask

  task automatic send_end();
    send_item(1'b1, 8'h00);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Drop valid, wait for every expected event, then allow for a result still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input csvp_pkg::csvp_cfg_idx_t idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input int unsigned cols, input int unsigned chars,
                            input int unsigned rows);
    wait_idle();
    write_reg(csvp_pkg::CFG_MAX_COLUMNS, cols[14:0]);
    write_reg(csvp_pkg::CFG_MAX_FIELD_CHARS, chars[14:0]);
    write_reg(csvp_pkg::CFG_MAX_ROWS, rows[14:0]);
  endtask

  // Random byte for field text, with the delimiters folded to a plain letter.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == csvp_pkg::CH_QUOTE || b == csvp_pkg::CH_COMMA ||
        b == csvp_pkg::CH_CR || b == csvp_pkg::CH_LF) b = 8'h61;
    return b;
  endfunction

  // Quoted fields: doubled quote, a quote as data mid-field, close then trailing
  // text, CRLF as one row end, CR right before end of data.
  task automatic test_quoting();
    send_text("\"a\"\"b\",x\"y");
    send_byte(csvp_pkg::CH_CR);
    send_byte(csvp_pkg::CH_LF);
    send_text("\"c\"d");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(csvp_pkg::CH_CR);
    send_end();
  endtask

  // End of data inside an open quote, then with the closing quote still pending.
  task automatic test_open_quote();
    send_text("\"u,");
    send_byte(csvp_pkg::CH_LF);
    send_end();
    send_text("\"v\"");
    send_end();
  endtask

  // Tightest limits: one column, no stored characters, one row.
  task automatic test_limits();
    set_limits(1, 0, 1);
    send_text("a\"b,c");
    send_byte(csvp_pkg::CH_LF);
    send_byte(8'h64);
    send_end();
  endtask

  // Random CSV rows with random content; some noise, stray ends and unclosed quotes.
  task automatic test_random(input int unsigned budget, input int unsigned s_pct,
                             input int unsigned r_pct, input int unsigned cols,
                             input int unsigned chars, input int unsigned rows);
    int unsigned stop;
    int unsigned n_fields;
    int unsigned f_len;
    int unsigned pick;
    set_limits(cols, chars, rows);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end else if (pick < 11) begin
        send_end();
      end else begin
        n_fields = ($urandom_range(9) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 5);
        for (int f = 0; f < n_fields; f++) begin
          if (f != 0) send_byte(csvp_pkg::CH_COMMA);
          f_len = ($urandom_range(19) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
          if ($urandom_range(2) == 0) begin
            send_byte(csvp_pkg::CH_QUOTE);
            repeat (f_len) begin
              case ($urandom_range(9))
                0: begin
                  send_byte(csvp_pkg::CH_QUOTE);
                  send_byte(csvp_pkg::CH_QUOTE);
                end
                1: send_byte(csvp_pkg::CH_COMMA);
                2: send_byte($urandom_range(1) ? csvp_pkg::CH_CR : csvp_pkg::CH_LF);
                default: send_byte(text_byte());
              endcase
            end
            // Leave the quote open now and then.
            if ($urandom_range(15) != 0) send_byte(csvp_pkg::CH_QUOTE);
          end else begin
            repeat (f_len) send_byte(text_byte());
          end
        end
        case ($urandom_range(3))
          0: send_byte(csvp_pkg::CH_CR);
          1: send_byte(csvp_pkg::CH_LF);
          2: begin
            send_byte(csvp_pkg::CH_CR);
            send_byte(csvp_pkg::CH_LF);
          end
          default: send_end();
        endcase
      end
    end
  endtask

  // Run the column counter and the widest row past their top values.
  task automatic test_column_saturation();
    set_limits(csvp_pkg::COLUMN_CAPACITY, 1023, 16384);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 12; i++) send_byte(8'(8'h41 + i));
    repeat (70) send_byte(csvp_pkg::CH_COMMA);
    send_byte(csvp_pkg::CH_LF);
    send_text("z,y");
    send_byte(csvp_pkg::CH_CR);
    send_end();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_quoting();
    test_open_quote();
    test_limits();
    test_random(190, 6, 78, 3, 4, 5);
    test_random(190, 78, 6, $urandom_range(1, 26), $urandom_range(0, 8),
                $urandom_range(1, 8));
    test_random(190, 0, 0, csvp_pkg::COLUMN_CAPACITY, 1023, 16384);
    test_column_saturation();
    wait_idle();
    $display("Covered %0d input transfers and %0d checked events: quoting, open quotes,",
             bytes_taken, events_seen);
    $display("limit extremes, column saturation and random CSV under three stall patterns.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
